// ===== rtl/swt_pkg.sv =====
// Shared constants and types of the spike window trigger.
`default_nettype none
package swt_pkg;
    localparam int DEPTH      = 16;
    localparam int UNIT_COUNT = 192;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int OCC_W      = $clog2(DEPTH + 1);

    localparam logic [1:0] REQ_SYL  = 2'd0;
    localparam logic [1:0] REQ_SPK  = 2'd1;
    localparam logic [1:0] REQ_TICK = 2'd2;
    localparam logic [1:0] REQ_NONE = 2'd3;

    localparam logic [1:0] KIND_RAISE = 2'd0;
    localparam logic [1:0] KIND_LOWER = 2'd1;
    localparam logic [1:0] KIND_CLOSE = 2'd2;
    localparam logic [1:0] KIND_DROP  = 2'd3;

    localparam logic [2:0] CFG_WSTART = 3'd0;
    localparam logic [2:0] CFG_WEND   = 3'd1;
    localparam logic [2:0] CFG_THR    = 3'd2;
    localparam logic [2:0] CFG_EXP    = 3'd3;
    localparam logic [2:0] CFG_PULSE  = 3'd4;
    localparam logic [2:0] CFG_MLO    = 3'd5;
    localparam logic [2:0] CFG_MMID   = 3'd6;
    localparam logic [2:0] CFG_MHI    = 3'd7;

    typedef struct packed {
        logic signed [47:0] time_us;
        logic [15:0]        code;
        logic [47:0]        sample;
        logic [7:0]         count;
        logic               fired;
        logic [31:0]        arrival;
    } t_entry;

    // Per-cell controls from the sequencer.
    typedef struct packed {
        logic               load;    // write the chain entry
        logic               shift;   // pop head: every cell but the last takes its neighbor
        logic               spike;   // evaluate a spike
        logic signed [47:0] spike_t;
        logic signed [31:0] wstart;
        logic signed [31:0] wend;
        logic [7:0]         thr;
        logic               clr;     // clear pending-report flags
    } t_cell_ctl;
endpackage
`default_nettype wire

// ===== rtl/swt_cell.sv =====
// One trial slot of the store chain: window compare, count and shift.
`default_nettype none
module swt_cell (
    input  wire logic               i_clk,
    input  wire swt_pkg::t_cell_ctl i_ctl,
    input  wire logic               i_valid,     // cell lies within occupancy
    input  wire logic               i_sel_load,  // this cell is the tail
    input  wire swt_pkg::t_entry    i_load,
    input  wire swt_pkg::t_entry    i_nbr,       // entry of next younger cell
    input  wire logic               i_nbr_rep,
    input  wire logic               i_ack,       // report taken for this cell
    output swt_pkg::t_entry         o_entry,
    output logic                    o_rep
);
    swt_pkg::t_entry r_e, n_e;
    logic            r_rep, n_rep;
    logic signed [48:0] w_dt;
    logic               w_hit;
    logic [7:0]         w_cnt;

    // Window check and saturating count.
    always_comb begin
        w_dt  = {i_ctl.spike_t[47], i_ctl.spike_t} - {r_e.time_us[47], r_e.time_us};
        w_hit = i_valid && !r_e.fired &&
                (w_dt >= 49'(i_ctl.wstart)) && (w_dt <= 49'(i_ctl.wend));
        w_cnt = (r_e.count == 8'hFF) ? r_e.count : r_e.count + 8'd1;
    end

    // Select load, shift or update.
    always_comb begin
        n_e   = r_e;
        n_rep = r_rep && !i_ack && !i_ctl.clr;
        if (i_ctl.load && i_sel_load) begin
            n_e   = i_load;
            n_rep = 1'b0;
        end else if (i_ctl.shift) begin
            n_e   = i_nbr;
            n_rep = i_nbr_rep;
        end else if (i_ctl.spike && w_hit) begin
            n_e.count = w_cnt;
            if (w_cnt >= i_ctl.thr) begin
                n_e.fired = 1'b1;
                n_rep     = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_e   <= n_e;
        r_rep <= n_rep;
    end

    assign o_entry = r_e;
    assign o_rep   = r_rep;
endmodule
`default_nettype wire

// ===== rtl/spike_window_trigger_core.sv =====
// Top level: configuration, trial chain, sequencer and output register.
//
// channel | dir | handshake          | payload
// in      | in  | i_valid / o_stall  | req_type, event_time, unit_id, code, sample
// out     | out | o_valid / i_stall  | kind, trial fields, hit_count, triggered, last
// cfg     | in  | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// One item at a time. A syllable is written to the tail cell, or dropped when the
// store is full; a spike on an enabled unit updates the window counts and reports
// each newly raised trial, oldest first; a tick closes expired trials and lowers
// the line when due. Each result waits in the output register for i_stall.
// The store is a row of DEPTH cells; the head pops by shifting the chain.
// Reset clears occupancy, tick count and line state; entries are not cleared.
`default_nettype none
module spike_window_trigger_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_req_type,
    input  wire logic signed [47:0] i_event_time,
    input  wire logic [7:0]         i_unit_id,
    input  wire logic [15:0]        i_syllable_code,
    input  wire logic [47:0]        i_sample_index,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [1:0]              o_kind,
    output logic [15:0]             o_trial_code,
    output logic [47:0]             o_trial_sample,
    output logic signed [47:0]      o_trial_time,
    output logic [7:0]              o_hit_count,
    output logic                    o_was_triggered,
    output logic                    o_last,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [63:0]        i_cfg_data
);
    localparam int D = swt_pkg::DEPTH;
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SPK  = 3'd1;
    localparam logic [2:0] ST_RAISE= 3'd2;
    localparam logic [2:0] ST_TICK = 3'd3;
    localparam logic [2:0] ST_LOW  = 3'd4;

    logic signed [31:0] r_wstart, r_wend;
    logic [7:0]         r_thr;
    logic [31:0]        r_exp, r_pulse;
    logic [191:0]       r_mask;

    logic [2:0]  r_st, n_st;
    logic [swt_pkg::OCC_W-1:0] r_occ, n_occ;
    logic [31:0] r_tick, n_tick;
    logic        r_line, n_line;
    logic [31:0] r_dl, n_dl;
    logic [1:0]              r_req;
    logic signed [47:0]      r_t;
    logic [7:0]              r_unit;
    logic [15:0]             r_code;
    logic [47:0]             r_samp;

    logic                    r_ov, n_ov;
    logic [1:0]              r_kind, n_kind;
    swt_pkg::t_entry         r_oe, n_oe;
    logic                    r_olast, n_olast;

    swt_pkg::t_cell_ctl w_ctl;
    swt_pkg::t_entry    w_load;
    swt_pkg::t_entry    w_ent [D];
    logic [D-1:0]       w_rep;
    logic [D-1:0]       w_ack;
    logic [D-1:0]       w_first;

    // Row of trial cells; cell 0 is the oldest.
    for (genvar g = 0; g < D; g++) begin : g_cell
        swt_pkg::t_entry w_nbr;
        logic            w_nrep;
        if (g == D - 1) begin : g_end
            assign w_nbr  = w_ent[g];
            assign w_nrep = 1'b0;
        end else begin : g_mid
            assign w_nbr  = w_ent[g+1];
            assign w_nrep = w_rep[g+1];
        end
        swt_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_valid    (swt_pkg::OCC_W'(g) < r_occ),
            .i_sel_load (swt_pkg::OCC_W'(g) == r_occ),
            .i_load     (w_load),
            .i_nbr      (w_nbr),
            .i_nbr_rep  (w_nrep),
            .i_ack      (w_ack[g]),
            .o_entry    (w_ent[g]),
            .o_rep      (w_rep[g])
        );
    end

    // Oldest pending raise report.
    always_comb begin
        w_first = w_rep & (~w_rep + D'(1));
    end

    logic w_oready, w_en, w_more;
    logic [31:0] w_ldue;
    assign w_oready = !r_ov || !i_stall;
    assign w_ldue = r_tick - r_dl;
    assign w_en   = (r_unit < 8'(swt_pkg::UNIT_COUNT)) && r_mask[r_unit];
    assign w_more = |(w_rep & ~w_first);

    assign w_load = '{time_us: r_t, code: r_code, sample: r_samp, count: 8'd0,
                      fired: 1'b0, arrival: r_tick};

    // Sequencer.
    always_comb begin
        n_st = r_st; n_occ = r_occ; n_tick = r_tick; n_line = r_line; n_dl = r_dl;
        n_ov = r_ov && i_stall; n_kind = r_kind; n_oe = r_oe; n_olast = r_olast;
        w_ctl = '{spike_t: r_t, wstart: r_wstart, wend: r_wend, thr: r_thr,
                  default: 1'b0};
        w_ack = '0;
        case (r_st)
            ST_IDLE: begin
                if (i_valid) begin
                    case (i_req_type)
                        swt_pkg::REQ_SYL:  n_st = ST_SPK;
                        swt_pkg::REQ_SPK:  n_st = ST_SPK;
                        swt_pkg::REQ_TICK: begin
                            n_st = ST_TICK; n_tick = r_tick + 32'd1;
                        end
                        default: n_st = ST_IDLE;
                    endcase
                end
            end
            ST_SPK: begin
                if (r_req == swt_pkg::REQ_SYL) begin
                    if (r_occ == swt_pkg::OCC_W'(D)) begin
                        if (w_oready) begin
                            n_ov = 1'b1; n_kind = swt_pkg::KIND_DROP; n_olast = 1'b1;
                            n_oe = '{time_us: r_t, code: r_code, sample: r_samp,
                                     default: '0};
                            n_st = ST_IDLE;
                        end
                    end else begin
                        w_ctl.load = 1'b1; n_occ = r_occ + 1'b1; n_st = ST_IDLE;
                    end
                end else begin
                    w_ctl.clr = 1'b1;
                    w_ctl.spike = w_en;
                    n_st = w_en ? ST_RAISE : ST_IDLE;
                end
            end
            ST_RAISE: begin
                if (w_rep == '0) begin
                    n_st = ST_IDLE;
                end else if (w_oready) begin
                    w_ack = w_first;
                    n_line = 1'b1; n_dl = r_tick + r_pulse;
                    n_ov = 1'b1; n_kind = swt_pkg::KIND_RAISE; n_olast = !w_more;
                    n_oe = '0;
                    for (int k = 0; k < D; k++) if (w_first[k]) n_oe = w_ent[k];
                    if (!w_more) n_st = ST_IDLE;
                end
            end
            ST_TICK: begin
                n_tick = r_tick;
                if (r_occ != '0 && (r_tick - w_ent[0].arrival) >= r_exp) begin
                    if (w_oready) begin
                        w_ctl.shift = 1'b1; n_occ = r_occ - 1'b1;
                        n_ov = 1'b1; n_kind = swt_pkg::KIND_CLOSE; n_oe = w_ent[0];
                        n_olast = !((r_occ > swt_pkg::OCC_W'(1)) &&
                                  ((r_tick - w_ent[1].arrival) >= r_exp)) &&
                                  !(r_line && !w_ldue[31]);
                    end
                end else begin
                    n_st = ST_LOW;
                end
            end
            ST_LOW: begin
                if (r_line && !w_ldue[31]) begin
                    if (w_oready) begin
                        n_line = 1'b0; n_ov = 1'b1; n_kind = swt_pkg::KIND_LOWER;
                        n_oe = '0; n_olast = 1'b1; n_st = ST_IDLE;
                    end
                end else begin
                    n_st = ST_IDLE;
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_occ <= '0; r_tick <= '0; r_line <= 1'b0; r_dl <= '0;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st; r_occ <= n_occ; r_tick <= n_tick; r_line <= n_line;
            r_dl <= n_dl; r_ov <= n_ov;
        end
    end

    // Hold request and result payload.
    always_ff @(posedge i_clk) begin
        if (r_st == ST_IDLE && i_valid) begin
            r_req <= i_req_type; r_t <= i_event_time; r_unit <= i_unit_id;
            r_code <= i_syllable_code; r_samp <= i_sample_index;
        end
        r_kind <= n_kind; r_oe <= n_oe; r_olast <= n_olast;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wstart <= 32'sd0; r_wend <= 32'sd100000; r_thr <= 8'd1;
            r_exp <= 32'd150; r_pulse <= 32'd10; r_mask <= '1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                swt_pkg::CFG_WSTART: r_wstart <= i_cfg_data[31:0];
                swt_pkg::CFG_WEND:   r_wend   <= i_cfg_data[31:0];
                swt_pkg::CFG_THR:    r_thr    <= i_cfg_data[7:0];
                swt_pkg::CFG_EXP:    r_exp    <= i_cfg_data[31:0];
                swt_pkg::CFG_PULSE:  r_pulse  <= i_cfg_data[31:0];
                swt_pkg::CFG_MLO:    r_mask[63:0]    <= i_cfg_data;
                swt_pkg::CFG_MMID:   r_mask[127:64]  <= i_cfg_data;
                swt_pkg::CFG_MHI:    r_mask[191:128] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign o_stall         = (r_st != ST_IDLE);
    assign o_valid         = r_ov;
    assign o_kind          = r_kind;
    assign o_trial_code    = r_oe.code;
    assign o_trial_sample  = r_oe.sample;
    assign o_trial_time    = r_oe.time_us;
    assign o_hit_count     = r_oe.count;
    assign o_was_triggered = r_oe.fired;
    assign o_last          = r_olast;
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench of the spike window trigger core.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;
    localparam int RING        = 256;
    localparam int MAX_RES     = 17;
    localparam int MAX_ROWS    = 32;

    typedef struct packed {
        logic [1:0]         kind;
        logic [15:0]        code;
        logic [47:0]        sample;
        logic signed [47:0] time_us;
        logic [7:0]         count;
        logic               fired;
        logic               last;
    } t_result;

    typedef struct packed {
        logic [1:0]         req;
        logic signed [47:0] time_us;
        logic [7:0]         unit;
        logic [15:0]        code;
        logic [47:0]        sample;
    } t_request;

    // Directed row: request plus optional literal expectation of its first result.
    typedef struct {
        t_request req;
        bit       has_lit;
        t_result  lit;
    } t_row;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] in_req = '0;
    logic signed [47:0] in_time = '0;
    logic [7:0] in_unit = '0;
    logic [15:0] in_code = '0;
    logic [47:0] in_sample = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [1:0] out_kind;
    logic [15:0] out_code;
    logic [47:0] out_sample;
    logic signed [47:0] out_time;
    logic [7:0] out_count;
    logic out_fired;
    logic out_last;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [63:0] cfg_data = '0;

    spike_window_trigger_core dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_req_type(in_req), .i_event_time(in_time), .i_unit_id(in_unit),
        .i_syllable_code(in_code), .i_sample_index(in_sample),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_kind(out_kind), .o_trial_code(out_code), .o_trial_sample(out_sample),
        .o_trial_time(out_time), .o_hit_count(out_count),
        .o_was_triggered(out_fired), .o_last(out_last),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    // Trigger state mirror
    logic signed [31:0] win_lo, win_hi;
    logic [7:0]  thresh;
    logic [31:0] expire_after, pulse_len;
    logic [191:0] enabled_units;
    swt_pkg::t_entry trials [swt_pkg::DEPTH];
    int unsigned head, pending;
    logic [31:0] ticks, deadline;
    logic line_high;

    // Expected results in arrival order
    t_result exp_ring [RING];
    int exp_wr = 0;
    int exp_rd = 0;
    int errors = 0;
    int cycles = 0;
    int accepted = 0;
    int received = 0;
    int stall_left = 0;

    function automatic t_result make_result(logic [1:0] k, swt_pkg::t_entry e);
        t_result r;
        r.kind = k; r.code = e.code; r.sample = e.sample; r.time_us = e.time_us;
        r.count = e.count; r.fired = e.fired; r.last = 1'b0;
        return r;
    endfunction

    // Predict the results of one accepted request and queue them.
    function automatic int predict_trigger(t_request q);
        t_result res [MAX_RES];
        int n;
        swt_pkg::t_entry blank;
        int unsigned s;
        logic signed [48:0] dt;
        n = 0;
        blank = '0;
        case (q.req)
            swt_pkg::REQ_SYL: begin
                if (pending >= swt_pkg::DEPTH) begin
                    blank.code = q.code; blank.sample = q.sample; blank.time_us = q.time_us;
                    res[n] = make_result(swt_pkg::KIND_DROP, blank); n++;
                end else begin
                    s = (head + pending) % swt_pkg::DEPTH;
                    trials[s].time_us = q.time_us; trials[s].code = q.code;
                    trials[s].sample = q.sample; trials[s].count = '0;
                    trials[s].fired = 1'b0; trials[s].arrival = ticks;
                    pending++;
                end
            end
            swt_pkg::REQ_SPK: begin
                if (q.unit < swt_pkg::UNIT_COUNT && enabled_units[q.unit]) begin
                    for (int i = 0; i < pending; i++) begin
                        s = (head + i) % swt_pkg::DEPTH;
                        if (trials[s].fired) continue;
                        dt = 49'(q.time_us) - 49'(trials[s].time_us);
                        if (dt < 49'(win_lo) || dt > 49'(win_hi)) continue;
                        if (trials[s].count != 8'hFF) trials[s].count++;
                        if (trials[s].count >= thresh) begin
                            line_high = 1'b1;
                            deadline = ticks + pulse_len;
                            trials[s].fired = 1'b1;
                            res[n] = make_result(swt_pkg::KIND_RAISE, trials[s]); n++;
                        end
                    end
                end
            end
            swt_pkg::REQ_TICK: begin
                ticks++;
                while (pending > 0) begin
                    if (ticks - trials[head].arrival < expire_after) break;
                    res[n] = make_result(swt_pkg::KIND_CLOSE, trials[head]); n++;
                    head = (head + 1) % swt_pkg::DEPTH;
                    pending--;
                end
                if (line_high && (ticks - deadline) < 32'h8000_0000) begin
                    line_high = 1'b0;
                    res[n] = make_result(swt_pkg::KIND_LOWER, blank); n++;
                end
            end
            default: ;
        endcase
        if (n > 0) res[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) begin
            exp_ring[exp_wr % RING] = res[i];
            exp_wr++;
        end
        return n;
    endfunction

    // Mirror a register write in the predictor.
    function automatic void apply_setting(logic [2:0] idx, logic [63:0] v);
        case (idx)
            swt_pkg::CFG_WSTART: win_lo = v[31:0];
            swt_pkg::CFG_WEND:   win_hi = v[31:0];
            swt_pkg::CFG_THR:    thresh = v[7:0];
            swt_pkg::CFG_EXP:    expire_after = v[31:0];
            swt_pkg::CFG_PULSE:  pulse_len = v[31:0];
            swt_pkg::CFG_MLO:    enabled_units[63:0] = v;
            swt_pkg::CFG_MMID:   enabled_units[127:64] = v;
            swt_pkg::CFG_MHI:    enabled_units[191:128] = v;
            default: ;
        endcase
    endfunction

    task automatic write_setting(logic [2:0] idx, logic [63:0] v);
        cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_setting(idx, v);
    endtask

    // Wait until every expected result is in, then let the core settle.
    task automatic drain();
        while (exp_wr != exp_rd) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Send one request; keep valid high across back-to-back requests.
    task automatic send_request(t_request q, bit has_lit, t_result lit);
        int gap;
        int n;
        t_result first;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req <= q.req; in_time <= q.time_us; in_unit <= q.unit;
        in_code <= q.code; in_sample <= q.sample;
        do @(posedge clk); while (in_stall);
        n = predict_trigger(q);
        accepted++;
        first = '0;
        if (n > 0) first = exp_ring[(exp_wr - n) % RING];
        if (has_lit && (n == 0 || first != lit)) begin
            $display("%0t: table row mismatch, expected %p, predicted %p", $time, lit,
                     first);
            errors++;
        end
    endtask

    task automatic send_plain(t_request q);
        t_result none;
        none = '0;
        send_request(q, 1'b0, none);
    endtask

    function automatic t_request req_of(logic [1:0] r, logic signed [47:0] t, logic [7:0] u,
                                        logic [15:0] c, logic [47:0] s);
        t_request q;
        q.req = r; q.time_us = t; q.unit = u; q.code = c; q.sample = s;
        return q;
    endfunction

    // Result consumer with a drawn stall after each result.
    always @(posedge clk) begin
        int hold;
        t_result got, want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                got = {out_kind, out_code, out_sample, out_time, out_count, out_fired, out_last};
                received++;
                if (exp_wr == exp_rd) begin
                    $display("%0t: unexpected result %p", $time, got);
                    errors++;
                end else begin
                    want = exp_ring[exp_rd % RING];
                    exp_rd++;
                    if (got != want) begin
                        $display("%0t: result mismatch, expected %p, actual %p",
                                 $time, want, got);
                        errors++;
                    end
                end
                hold = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 17);
                stall_left = hold;
                out_stall <= hold != 0;
            end else if (out_stall) begin
                stall_left--;
                if (stall_left <= 0) out_stall <= 1'b0;
            end
        end
    end

    // Cycle limit
    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results pending",
                     cycles, exp_wr - exp_rd);
            $display("Verification failed");
            $finish;
        end
    end

    t_row table_rows [MAX_ROWS];
    int row_count = 0;

    task automatic add_row(t_request q, bit has_lit, t_result lit);
        t_row r;
        r.req = q; r.has_lit = has_lit; r.lit = lit;
        table_rows[row_count] = r;
        row_count++;
    endtask

    // Random request: mostly syllable/spike/tick mixes near open trials.
    function automatic t_request random_request(logic signed [47:0] base);
        t_request q;
        int pick;
        pick = $urandom_range(0, 99);
        q.unit = 8'($urandom_range(0, 191));
        q.code = 16'($urandom);
        q.sample = 48'({$urandom, $urandom});
        q.time_us = base + $signed(48'($urandom_range(0, 200000))) - 48'sd50000;
        if (pick < 2) q.unit = 8'($urandom_range(192, 255));
        if (pick < 4) q.time_us = 48'({$urandom, $urandom});
        if (pick < 20) q.req = swt_pkg::REQ_SYL;
        else if (pick < 65) q.req = swt_pkg::REQ_SPK;
        else if (pick < 98) q.req = swt_pkg::REQ_TICK;
        else q.req = swt_pkg::REQ_NONE;
        return q;
    endfunction

    initial begin
        t_result lit;
        t_request q;
        logic signed [47:0] base;
        // Reset values of the predictor
        win_lo = 0; win_hi = 100000; thresh = 1; expire_after = 150; pulse_len = 10;
        enabled_units = '1; head = 0; pending = 0; ticks = 0; deadline = 0;
        line_high = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: reset settings, extremes, drop, lower, ignored requests.
        lit = '0;
        add_row(req_of(swt_pkg::REQ_SYL, 48'sd1000, 8'd0, 16'hFFFF, 48'hFFFF_FFFF_FFFF),
                0, lit);
        lit = '{swt_pkg::KIND_RAISE, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 48'sd1000, 8'd1, 1'b1,
                1'b1};
        add_row(req_of(swt_pkg::REQ_SPK, 48'sd1000, 8'd191, 16'd0, 48'd0), 1, lit);
        add_row(req_of(swt_pkg::REQ_SPK, 48'sd2000, 8'd192, 16'd0, 48'd0), 0, lit);
        add_row(req_of(swt_pkg::REQ_NONE, 48'sd2000, 8'd0, 16'd0, 48'd0), 0, lit);
        add_row(req_of(swt_pkg::REQ_SYL, 48'sh7FFF_FFFF_FFFF, 8'd0, 16'd1, 48'd0), 0, lit);
        add_row(req_of(swt_pkg::REQ_SPK, 48'sh8000_0000_0000, 8'd255, 16'd0, 48'd0), 0, lit);
        add_row(req_of(swt_pkg::REQ_SPK, 48'sh7FFF_FFFF_FFFF, 8'd64, 16'd0, 48'd0), 0, lit);
        for (int i = 0; i < 14; i++)
            add_row(req_of(swt_pkg::REQ_SYL, 48'(i * 10), 8'd0, 16'(i), 48'(i)), 0, lit);
        lit = '{swt_pkg::KIND_DROP, 16'h0055, 48'd7, 48'sd0, 8'd0, 1'b0, 1'b1};
        add_row(req_of(swt_pkg::REQ_SYL, 48'sd0, 8'd0, 16'h0055, 48'd7), 1, lit);
        add_row(req_of(swt_pkg::REQ_SPK, 48'sd50, 8'd127, 16'd0, 48'd0), 0, lit);
        add_row(req_of(swt_pkg::REQ_TICK, 48'sd0, 8'd0, 16'd0, 48'd0), 0, lit);
        for (int i = 0; i < row_count; i++)
            send_request(table_rows[i].req, table_rows[i].has_lit, table_rows[i].lit);
        // Run ticks until the store empties and the line drops.
        for (int i = 0; i < 160; i++)
            send_plain(req_of(swt_pkg::REQ_TICK, 48'sd0, 8'd0, 16'd0, 48'd0));
        in_valid <= 1'b0;
        drain();

        // Random phases over several settings, extremes included.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_setting(swt_pkg::CFG_THR, 64'd255);
                    write_setting(swt_pkg::CFG_EXP, 64'd0);
                    write_setting(swt_pkg::CFG_PULSE, 64'd0);
                    write_setting(swt_pkg::CFG_WSTART, 64'h8000_0000);
                    write_setting(swt_pkg::CFG_WEND, 64'h7FFF_FFFF);
                end
                1: begin
                    write_setting(swt_pkg::CFG_THR, 64'd2);
                    write_setting(swt_pkg::CFG_EXP, 64'd12);
                    write_setting(swt_pkg::CFG_PULSE, 64'd3);
                    write_setting(swt_pkg::CFG_WSTART, 64'hFFFF_FFFF_FFFF_0000);
                    write_setting(swt_pkg::CFG_WEND, 64'd60000);
                    write_setting(swt_pkg::CFG_MLO, {$urandom, $urandom});
                    write_setting(swt_pkg::CFG_MMID, {$urandom, $urandom});
                    write_setting(swt_pkg::CFG_MHI, {$urandom, $urandom});
                end
                2: begin
                    write_setting(swt_pkg::CFG_THR, 64'd0);
                    write_setting(swt_pkg::CFG_EXP, 64'hFFFF_FFFF);
                    write_setting(swt_pkg::CFG_PULSE, 64'hFFFF_FFFF);
                    write_setting(swt_pkg::CFG_MLO, 64'd0);
                    write_setting(swt_pkg::CFG_MMID, '1);
                    write_setting(swt_pkg::CFG_MHI, 64'd0);
                end
                3: begin
                    write_setting(swt_pkg::CFG_EXP, 64'd1);
                    write_setting(swt_pkg::CFG_PULSE, 64'h8000_0000);
                    write_setting(swt_pkg::CFG_THR, 64'd1);
                    write_setting(swt_pkg::CFG_MLO, '1);
                    write_setting(swt_pkg::CFG_MHI, '1);
                end
                4: begin
                    write_setting(swt_pkg::CFG_THR, 64'd3);
                    write_setting(swt_pkg::CFG_EXP, 64'd20);
                    write_setting(swt_pkg::CFG_PULSE, 64'd5);
                    write_setting(swt_pkg::CFG_WSTART, 64'd0);
                    write_setting(swt_pkg::CFG_WEND, 64'd100000);
                end
                default: begin
                    write_setting(swt_pkg::CFG_WSTART, 64'd80000);
                    write_setting(swt_pkg::CFG_WEND, 64'd20000);
                end
            endcase
            base = 48'({$urandom, $urandom});
            for (int i = 0; i < 20; i++) begin
                q = random_request(base);
                if (q.req == swt_pkg::REQ_SYL && $urandom_range(0, 1)) base = q.time_us;
                send_plain(q);
                // Hold off once per phase until everything has come back.
                if (i == 10) begin
                    in_valid <= 1'b0;
                    while (exp_wr != exp_rd) @(posedge clk);
                end
            end
            // Close every trial before changing settings.
            write_after_flush: begin
                in_valid <= 1'b0;
                drain();
                write_setting(swt_pkg::CFG_EXP, 64'd1);
                send_plain(req_of(swt_pkg::REQ_TICK, 48'sd0, 8'd0, 16'd0, 48'd0));
                send_plain(req_of(swt_pkg::REQ_TICK, 48'sd0, 8'd0, 16'd0, 48'd0));
                in_valid <= 1'b0;
                drain();
            end
        end

        $display("Sent %0d requests over 7 setting phases, checked %0d results",
                 accepted, received);
        if (errors == 0 && exp_wr == exp_rd) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
rtl/swt_pkg.sv
rtl/swt_cell.sv
rtl/spike_window_trigger_core.sv
tb/tb_top.sv
